// ----- src/qac_pkg.sv -----
// Shared types, constants and tables for the quaternion attitude converter.
package qac_pkg;

  localparam int QW         = 16;
  localparam int VW         = 48;
  localparam int SW         = 5;
  localparam int AW         = 40;
  localparam int ZW         = 32;
  localparam int CNT_W      = 10;
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int STEPS      = 23;
  localparam int STEP_W     = 5;
  localparam int NSLOT      = 22;

  localparam logic [CNT_W-1:0] WARMUP_RST = 10'd500;
  localparam logic [THR_W-1:0] THRESH_RST = 9'd200;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'd1;

  localparam logic signed [AW-1:0] ONE_Q28    = 40'sd268435456;
  localparam logic signed [ZW-1:0] DEG90_Q16  = 32'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 32'sd11796480;
  localparam logic signed [VW-1:0] DEG360_Q16 = 48'sd23592960;

  // cordic unit requests
  typedef struct packed {
    logic                 start;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] x;
  } cordic_req_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 32'd2949120;   5'd1: r = 32'd1740967;
      5'd2: r = 32'd919879;    5'd3: r = 32'd466945;
      5'd4: r = 32'd234379;    5'd5: r = 32'd117304;
      5'd6: r = 32'd58666;     5'd7: r = 32'd29335;
      5'd8: r = 32'd14668;     5'd9: r = 32'd7334;
      5'd10: r = 32'd3667;     5'd11: r = 32'd1833;
      5'd12: r = 32'd917;      5'd13: r = 32'd458;
      5'd14: r = 32'd229;      5'd15: r = 32'd115;
      5'd16: r = 32'd57;       5'd17: r = 32'd29;
      5'd18: r = 32'd14;       5'd19: r = 32'd7;
      5'd20: r = 32'd4;        5'd21: r = 32'd2;
      5'd22: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/quaternion_attitude_convert.sv -----
// Top level: quaternion to rotation matrix, Euler angles and unwrapped yaw.
//  channel | signals                                   | dir
//  in      | in_valid in_ready quat_w/x/y/z            | in
//  out     | out_valid out_ready slot value sum_valid last | out
//  cfg     | cfg_we cfg_idx cfg_data                   | in
// After acceptance a word goes through products on one shared multiplier,
// CORDIC for roll, isqrt, CORDIC for pitch (skipped when clamped) and yaw,
// CORDIC shortened for a zero vector, then unwrap and 22 output words.
// Not ready while a word is in work. Sync reset clears control, counters and
// unwrap state.
// out_ready low holds the current output word.
module quaternion_attitude_convert (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qac_pkg::QW-1:0]       quat_w,
  input  logic signed [qac_pkg::QW-1:0]       quat_x,
  input  logic signed [qac_pkg::QW-1:0]       quat_y,
  input  logic signed [qac_pkg::QW-1:0]       quat_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qac_pkg::SW-1:0]              slot,
  output logic signed [qac_pkg::VW-1:0]       value,
  output logic                                sum_valid,
  output logic                                last,
  input  logic                                cfg_we,
  input  logic [qac_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [qac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_ROLL = 3'd2, S_SQRT = 3'd3,
                         S_PITCH = 3'd4, S_YAW = 3'd5, S_UNWRAP = 3'd6, S_OUT = 3'd7;

  logic [2:0] state;
  logic [3:0] mcnt;
  logic signed [qac_pkg::QW-1:0] qw, qx, qy, qz;
  logic signed [31:0] p [10];   // ww wx wy wz xx xy xz yy yz zz
  logic signed [qac_pkg::QW-1:0] ma, mb;
  logic signed [31:0] prod;
  logic signed [qac_pkg::ZW-1:0] roll, pitch, yaw;
  logic [qac_pkg::CNT_W-1:0] warmup, item_count;
  logic [qac_pkg::THR_W-1:0] thresh;
  logic unwrap_started;
  logic signed [qac_pkg::ZW-1:0] previous_yaw;
  logic signed [qac_pkg::VW-1:0] yaw_sum;
  logic [qac_pkg::SW-1:0] oslot;
  logic cwait;
  qac_pkg::cordic_req_t creq;
  logic cdone, sq_start, sq_done;
  logic signed [qac_pkg::ZW-1:0] cangle;
  logic [qac_pkg::AW-1:0] root;
  logic signed [qac_pkg::AW-1:0] pv;
  logic [57:0] rad;
  logic signed [qac_pkg::AW-1:0] pv_sq;

  always_comb begin
    case (mcnt)
      4'd0: begin ma = qw; mb = qw; end
      4'd1: begin ma = qw; mb = qx; end
      4'd2: begin ma = qw; mb = qy; end
      4'd3: begin ma = qw; mb = qz; end
      4'd4: begin ma = qx; mb = qx; end
      4'd5: begin ma = qx; mb = qy; end
      4'd6: begin ma = qx; mb = qz; end
      4'd7: begin ma = qy; mb = qy; end
      4'd8: begin ma = qy; mb = qz; end
      default: begin ma = qz; mb = qz; end
    endcase
  end
  assign prod = ma * mb;

  function automatic logic signed [qac_pkg::AW-1:0] e(input logic signed [31:0] v);
    return qac_pkg::AW'(v);
  endfunction

  logic signed [qac_pkg::AW-1:0] roll_y, roll_x, yaw_y, yaw_x;
  assign roll_y = 2 * (e(p[1]) + e(p[8]));
  assign roll_x = qac_pkg::ONE_Q28 - 2 * (e(p[4]) + e(p[7]));
  assign yaw_y  = 2 * (e(p[5]) + e(p[3]));
  assign yaw_x  = qac_pkg::ONE_Q28 - 2 * (e(p[7]) + e(p[9]));
  assign pv     = 2 * (e(p[2]) - e(p[6]));
  assign pv_sq  = (pv < 0) ? -pv : pv;
  // pv^2 exceeds one multiplier; the isqrt argument uses 1-v^2 = (1-|v|)(1+|v|)
  logic [29:0] om, op;
  assign om  = 30'(qac_pkg::ONE_Q28 - pv_sq);
  assign op  = 30'(qac_pkg::ONE_Q28 + pv_sq);
  logic [57:0] rad_r;
  always_ff @(posedge clk) rad_r <= 58'(om) * 58'(op);
  assign rad = rad_r;

  logic pclamp;
  assign pclamp = (pv >= qac_pkg::ONE_Q28) || (pv <= -qac_pkg::ONE_Q28);

  always_comb begin
    creq = '0;
    if (!cwait) begin
      if (state == S_ROLL) begin
        creq.start = 1'b1; creq.y = roll_y; creq.x = roll_x;
      end else if (state == S_PITCH && !pclamp) begin
        creq.start = 1'b1; creq.y = pv; creq.x = root;
      end else if (state == S_YAW) begin
        creq.start = 1'b1; creq.y = yaw_y; creq.x = yaw_x;
      end
    end
  end

  qac_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .done(cdone), .angle(cangle));
  qac_isqrt  u_isqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(rad),
                      .done(sq_done), .root(root));

  logic sq_go;
  assign sq_start = (state == S_SQRT) && !sq_go;

  // unwrap math
  logic [qac_pkg::CNT_W-1:0] cnt_next;
  logic active, first;
  logic signed [qac_pkg::VW-1:0] err, err_adj, mag, sum_next;
  logic signed [qac_pkg::VW:0] sum_wide;
  logic signed [qac_pkg::ZW-1:0] pref;
  assign cnt_next = (item_count == '1) ? item_count : item_count + 1'b1;
  assign active   = cnt_next >= warmup;
  assign first    = !unwrap_started;
  assign pref     = first ? yaw : previous_yaw;
  assign err      = qac_pkg::VW'(yaw) - qac_pkg::VW'(pref);
  assign mag      = ((err < 0) ? -err : err) >>> 16;
  always_comb begin
    err_adj = err;
    if (mag > $signed({39'd0, thresh}))
      err_adj = (err >= 0) ? err - qac_pkg::DEG360_Q16 : err + qac_pkg::DEG360_Q16;
  end
  assign sum_wide = (first ? '0 : (qac_pkg::VW+1)'(yaw_sum)) + (qac_pkg::VW+1)'(err_adj);
  always_comb begin
    if (sum_wide > $signed({2'b00, {(qac_pkg::VW-1){1'b1}}}))
      sum_next = {1'b0, {(qac_pkg::VW-1){1'b1}}};
    else if (sum_wide < $signed({2'b11, {(qac_pkg::VW-1){1'b0}}}))
      sum_next = {1'b1, {(qac_pkg::VW-1){1'b0}}};
    else
      sum_next = qac_pkg::VW'(sum_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; mcnt <= '0; cwait <= 1'b0; sq_go <= 1'b0;
      warmup <= qac_pkg::WARMUP_RST; thresh <= qac_pkg::THRESH_RST;
      item_count <= '0; unwrap_started <= 1'b0; previous_yaw <= '0; yaw_sum <= '0;
      oslot <= '0;
    end else begin
      if (cfg_we && cfg_idx == qac_pkg::REG_WARMUP) warmup <= cfg_data;
      if (cfg_we && cfg_idx == qac_pkg::REG_THRESH) thresh <= cfg_data[qac_pkg::THR_W-1:0];
      case (state)
        S_IDLE: if (in_valid) begin
          qw <= quat_w; qx <= quat_x; qy <= quat_y; qz <= quat_z;
          mcnt <= '0; state <= S_MUL;
        end
        S_MUL: begin
          p[mcnt] <= prod;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 4'd9) state <= S_ROLL;
        end
        S_ROLL: begin
          cwait <= 1'b1;
          if (cwait && cdone) begin
            roll <= cangle; cwait <= 1'b0; state <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_go <= 1'b1;
          if (sq_go && sq_done) begin sq_go <= 1'b0; state <= S_PITCH; end
        end
        S_PITCH: begin
          if (pclamp) begin
            pitch <= (pv > 0) ? -qac_pkg::DEG90_Q16 : qac_pkg::DEG90_Q16;
            state <= S_YAW;
          end else begin
            cwait <= 1'b1;
            if (cwait && cdone) begin
              pitch <= -cangle; cwait <= 1'b0; state <= S_YAW;
            end
          end
        end
        S_YAW: begin
          cwait <= 1'b1;
          if (cwait && cdone) begin
            yaw <= -cangle; cwait <= 1'b0; state <= S_UNWRAP;
          end
        end
        S_UNWRAP: begin
          item_count <= cnt_next;
          if (active) begin
            unwrap_started <= 1'b1; previous_yaw <= yaw; yaw_sum <= sum_next;
          end
          oslot <= '0; state <= S_OUT;
        end
        default: if (out_ready) begin
          oslot <= oslot + 1'b1;
          if (oslot == qac_pkg::SW'(qac_pkg::NSLOT - 1)) state <= S_IDLE;
        end
      endcase
    end
  end

  // matrix entries from stored products, round to Q16
  logic signed [qac_pkg::AW-1:0] m28;
  logic signed [qac_pkg::AW-1:0] ww, wx, wy, wz, xx, xy, xz, yy, yz, zz, one;
  assign ww = e(p[0]); assign wx = e(p[1]); assign wy = e(p[2]); assign wz = e(p[3]);
  assign xx = e(p[4]); assign xy = e(p[5]); assign xz = e(p[6]); assign yy = e(p[7]);
  assign yz = e(p[8]); assign zz = e(p[9]); assign one = qac_pkg::ONE_Q28;
  always_comb begin
    case (oslot)
      5'd0: m28 = 2 * (ww + xx) - one;
      5'd1, 5'd12: m28 = 2 * (xy - wz);
      5'd2, 5'd15: m28 = 2 * (xz + wy);
      5'd3, 5'd10: m28 = 2 * (xy + wz);
      5'd4: m28 = 2 * (ww + yy) - one;
      5'd5, 5'd16: m28 = 2 * (yz - wx);
      5'd6, 5'd11: m28 = 2 * (xz - wy);
      5'd7, 5'd14: m28 = 2 * (yz + wx);
      5'd8: m28 = 2 * (ww + zz) - one;
      5'd9: m28 = ww + xx - yy - zz;
      5'd13: m28 = ww - xx + yy - zz;
      default: m28 = ww - xx - yy + zz;
    endcase
  end
  logic signed [qac_pkg::AW-1:0] m16;
  assign m16 = (m28 + 40'sd2048) >>> 12;

  always_comb begin
    case (oslot)
      5'd18: value = qac_pkg::VW'(roll);
      5'd19: value = qac_pkg::VW'(pitch);
      5'd20: value = qac_pkg::VW'(yaw);
      5'd21: value = yaw_sum;
      default: value = qac_pkg::VW'(m16);
    endcase
  end
  assign slot      = oslot;
  assign out_valid = (state == S_OUT);
  assign last      = (oslot == qac_pkg::SW'(qac_pkg::NSLOT - 1));
  assign sum_valid = unwrap_started;
  assign in_ready  = (state == S_IDLE);
endmodule

// ----- src/qac_isqrt.sv -----
// Bit-serial integer square root, two radicand bits per pass, one pass a cycle.
module qac_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [57:0]                   radicand,
  output logic                          done,
  output logic [qac_pkg::AW-1:0]        root
);
  logic [57:0] rem;
  logic [57:0] res;
  logic [57:0] bitv;
  logic        busy;
  logic [57:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 58'h1 << 56;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = {{(qac_pkg::AW-29){1'b0}}, res[28:0]};
endmodule

// ----- src/qac_cordic.sv -----
// Shared vectoring-mode CORDIC: atan2 in Q16 degrees, one micro-rotation a cycle.
module qac_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  qac_pkg::cordic_req_t         req,
  output logic                         done,
  output logic signed [qac_pkg::ZW-1:0] angle
);
  logic signed [qac_pkg::AW-1:0] x;
  logic signed [qac_pkg::AW-1:0] y;
  logic signed [qac_pkg::ZW-1:0] z;
  logic [qac_pkg::STEP_W-1:0]    i;
  logic                          busy;
  logic signed [qac_pkg::AW-1:0] dx;
  logic signed [qac_pkg::AW-1:0] dy;
  logic signed [qac_pkg::ZW-1:0] at;

  assign dx = y >>> i;
  assign dy = x >>> i;
  assign at = $signed(qac_pkg::atan_lut(i));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        i <= '0;
        if (req.x == '0 && req.y == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (req.x < 0 && req.y >= 0) begin
            x <= req.y; y <= -req.x; z <= qac_pkg::DEG90_Q16;
          end else if (req.x < 0) begin
            x <= -req.y; y <= req.x; z <= -qac_pkg::DEG90_Q16;
          end else begin
            x <= req.x; y <= req.y; z <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end else begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end
        i <= i + 1'b1;
        if (i == qac_pkg::STEP_W'(qac_pkg::STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign angle = z;
endmodule

// ----- src/qac_checker.sv -----
// Port-level checks for the quaternion attitude converter.
module qac_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [qac_pkg::SW-1:0]         slot,
  input logic                           last,
  input logic                           sum_valid
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while words pending");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (slot == 5'd21))) else $error("last misplaced");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && slot == $past(slot) + 5'd1)
    else $error("slot sequence broken");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot)) else $error("output dropped");
  a_sv: assert property (@(posedge clk) disable iff (rst)
    $past(sum_valid) && !$past(rst) |-> sum_valid) else $error("sum_valid fell");
endmodule

bind quaternion_attitude_convert qac_checker u_qac_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .slot(slot), .last(last),
  .sum_valid(sum_valid));
